// ----- rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;
	localparam int unsigned FrameTotalDefault = 65536;
	localparam int unsigned WordBitsDefault   = 64;
	localparam int unsigned RegW   = 17;
	localparam int unsigned FrameW = 16;
	localparam int unsigned OpW    = 2;
	localparam int unsigned CfgIdxW = 1;

	typedef enum logic [OpW-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_MARK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [CfgIdxW-1:0] CFG_RANGE_FIRST = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_RANGE_LIMIT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // latch the request and start a scan
		logic rd;        // read the bitmap word under the cursor
		logic step;      // advance the cursor and the run offset by one frame
		logic restart;   // move the candidate past a used frame
		logic rewind;    // rewind the cursor to the candidate for marking
		logic modify;    // set or clear the cursor's bit in the word register
		logic wr;        // write the word register back to the bitmap
	} bfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic run_done;  // offset reached the count
		logic past_limit;
		logic frame_used;
		logic word_last; // cursor sits on the last bit of its word
		logic chunk_end; // last bit of the word, or last frame of the run
	} bfa_sts_t;
endpackage

// ----- rtl/bfa_if.sv -----
// ----------------------------------------------------------------------------
// bfa_req_if / bfa_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface bfa_req_if;
	import bfa_pkg::*;
	logic              valid;
	logic              ready;
	logic [OpW-1:0]    op;
	logic [FrameW-1:0] first_frame;
	logic [RegW-1:0]   frame_count;
	modport source (output valid, op, first_frame, frame_count, input ready);
	modport sink (input valid, op, first_frame, frame_count, output ready);
endinterface

interface bfa_rsp_if;
	import bfa_pkg::*;
	logic              valid;
	logic              ready;
	logic              status;
	logic [FrameW-1:0] found_frame;
	modport source (output valid, status, found_frame, input ready);
	modport sink (input valid, status, found_frame, output ready);
endinterface

// ----- rtl/bitmap_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit bitmap page frame allocator with a one-bit-per-frame memory.
// ----------------------------------------------------------------------------
// channel  dir  signals
// req      in   valid ready op first_frame frame_count
// rsp      out  valid ready status found_frame
// cfg      in   cfg_we cfg_idx cfg_wdata
// The search tests one frame a cycle, pausing to read each bitmap word it
// enters. Setting or clearing a run walks it frame by frame, with a read and
// a write-back per word; an unused opcode goes straight to its answer. After
// reset a clear pass over every bitmap word (1024 by default) runs before
// the first request is taken. While a result waits, the next request is
// taken and held finished until the result register frees.
module bitmap_frame_allocator import bfa_pkg::*; #(
	parameter int unsigned FRAME_TOTAL = FrameTotalDefault,
	parameter int unsigned WORD_BITS   = WordBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	bfa_req_if.sink             req,
	bfa_rsp_if.source           rsp,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [RegW-1:0]     cfg_wdata
);
	logic [RegW-1:0]   range_first_q, range_limit_q;
	bfa_cmd_t          cmd;
	bfa_sts_t          sts;
	logic [FrameW-1:0] cand_frame;
	logic              clr_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= '0;
			range_limit_q <= RegW'(65536);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RANGE_FIRST: range_first_q <= cfg_wdata;
				CFG_RANGE_LIMIT: range_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bfa_datapath #(.FRAME_TOTAL(FRAME_TOTAL), .WORD_BITS(WORD_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.req_op(req.op), .req_first(req.first_frame), .req_count(req.frame_count),
		.range_first(range_first_q), .range_limit(range_limit_q),
		.cand_frame, .clr_done
	);

	bfa_ctrl u_ctrl (
		.clk, .arst_n, .clr_done, .req, .rsp, .cmd, .sts, .cand_frame
	);

`ifndef NO_ASSERTIONS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !req.ready) else $error("request taken during clear");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.found_frame == '0) else $error("bad fail frame");
`endif
endmodule

// ----- rtl/bfa_datapath.sv -----
// ----------------------------------------------------------------------------
// bfa_datapath
// Bitmap memory, frame cursor and run bookkeeping. The cursor walks frame by
// frame; a word is read when the cursor enters it, bits are tested or modified
// in a register and a modified word is written back when the cursor leaves it.
// ----------------------------------------------------------------------------
module bfa_datapath import bfa_pkg::*; #(
	parameter int unsigned FRAME_TOTAL = FrameTotalDefault,
	parameter int unsigned WORD_BITS   = WordBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfa_cmd_t          cmd,
	output bfa_sts_t          sts,
	input  logic [OpW-1:0]    req_op,
	input  logic [FrameW-1:0] req_first,
	input  logic [RegW-1:0]   req_count,
	input  logic [RegW-1:0]   range_first,
	input  logic [RegW-1:0]   range_limit,
	output logic [FrameW-1:0] cand_frame,
	output logic              clr_done
);
	// A word is stored with a power-of-two width so that the cursor splits
	// into a word address and a bit index without any division.
	localparam int unsigned BW        = $clog2(WORD_BITS);
	localparam int unsigned StoreBits = 1 << BW;
	localparam int unsigned Words     = (FRAME_TOTAL + StoreBits - 1) / StoreBits;
	localparam int unsigned AW        = (Words > 1) ? $clog2(Words) : 1;
	// A free or mark run can reach frame 65535 + 131071.
	localparam int unsigned CurW      = RegW + 1;

	logic [StoreBits-1:0] mem [Words];
	logic [StoreBits-1:0] word_q;
	logic [CurW-1:0]      cur_q, cand_q;
	logic [RegW-1:0]      cnt_q, off_q;
	logic                 set_q;
	logic [AW-1:0]        wa_q;
	logic                 wok_q;
	logic [AW:0]          clr_q;

	logic [31:0]   word_idx;
	logic [AW-1:0] waddr;
	logic          word_ok;
	logic [BW-1:0] bidx;
	logic          in_map;

	assign word_idx = 32'(cur_q >> BW);
	assign waddr    = word_idx[AW-1:0];
	assign word_ok  = word_idx < Words;
	assign bidx     = cur_q[BW-1:0];
	assign in_map   = 32'(cur_q) < FRAME_TOTAL;
	assign clr_done = clr_q[AW];

	assign sts.run_done   = (off_q == cnt_q);
	assign sts.past_limit = cur_q >= {1'b0, range_limit};
	assign sts.frame_used = in_map && word_q[bidx];
	assign sts.word_last  = &bidx;
	assign sts.chunk_end  = (&bidx) || (off_q + RegW'(1) == cnt_q);
	assign cand_frame     = cand_q[FrameW-1:0];

	// The clear pass sweeps the memory once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[AW]) begin
			if (clr_q[AW-1:0] == AW'(Words - 1)) clr_q <= {1'b1, {AW{1'b0}}};
			else clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			cand_q <= '0;
			cnt_q  <= '0;
			off_q  <= '0;
			set_q  <= 1'b0;
			wa_q   <= '0;
			wok_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (req_op == OP_ALLOC) begin
					cur_q  <= CurW'(range_first);
					cand_q <= CurW'(range_first);
				end else begin
					cur_q  <= CurW'(req_first);
					cand_q <= CurW'(req_first);
				end
				set_q <= (req_op != OP_FREE);
				cnt_q <= req_count;
				off_q <= '0;
			end else if (cmd.restart) begin
				cur_q  <= cur_q + 1'b1;
				cand_q <= cur_q + 1'b1;
				off_q  <= '0;
			end else if (cmd.rewind) begin
				cur_q <= cand_q;
				off_q <= '0;
			end else if (cmd.step) begin
				cur_q <= cur_q + 1'b1;
				off_q <= off_q + 1'b1;
			end
			if (cmd.rd) begin
				wa_q  <= waddr;
				wok_q <= word_ok;
			end
		end
	end

	// Words past the end of the memory read as free and are never written.
	always_ff @(posedge clk) begin
		if (!clr_done) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (cmd.wr && wok_q) begin
			mem[wa_q] <= word_q;
		end
		if (cmd.rd) begin
			if (word_ok) word_q <= mem[waddr];
			else word_q <= '0;
		end else if (cmd.modify && in_map) begin
			word_q[bidx] <= set_q;
		end
	end
endmodule

// ----- rtl/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: search phase tests one frame a cycle between word reads, write
// phase sets or clears one bit a cycle between word reads and write-backs and writes each touched word back.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr_done,
	bfa_req_if.sink           req,
	bfa_rsp_if.source         rsp,
	output bfa_cmd_t          cmd,
	input  bfa_sts_t          sts,
	input  logic [FrameW-1:0] cand_frame
);
	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_TEST, S_MOD, S_WB, S_RSP
	} state_t;

	state_t state_q;
	logic   alloc_q, search_q, fail_q;
	logic   rsp_load;

	assign req.ready = (state_q == S_IDLE) && clr_done;
	// The result register can take a new result when it is empty or when its
	// transfer happens in this cycle.
	assign rsp_load  = (state_q == S_RSP) && (!rsp.valid || rsp.ready);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = req.valid && req.ready;
			S_RD:   cmd.rd = 1'b1;
			S_TEST: begin
				if (sts.run_done) begin
					cmd.rewind = 1'b1;
				end else if (!sts.past_limit) begin
					if (sts.frame_used) cmd.restart = 1'b1;
					else cmd.step = 1'b1;
				end
			end
			S_MOD: if (!sts.run_done) begin
				cmd.modify = 1'b1;
				cmd.step = 1'b1;
			end
			S_WB:   cmd.wr = 1'b1;
			S_RSP:  ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alloc_q <= 1'b0;
			search_q <= 1'b0;
			fail_q <= 1'b0;
			rsp.valid <= 1'b0;
			rsp.status <= 1'b0;
			rsp.found_frame <= '0;
		end else begin
			if (rsp_load) begin
				rsp.valid <= 1'b1;
				rsp.status <= fail_q;
				rsp.found_frame <= (alloc_q && !fail_q) ? cand_frame : '0;
			end else if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					alloc_q <= (req.op == OP_ALLOC);
					search_q <= (req.op == OP_ALLOC);
					fail_q <= 1'b0;
					state_q <= (req.op == OP_NONE) ? S_RSP : S_RD;
				end
				S_RD: state_q <= search_q ? S_TEST : S_MOD;
				S_TEST: begin
					if (sts.run_done) begin
						search_q <= 1'b0;
						state_q <= S_RD;
					end else if (sts.past_limit) begin
						fail_q <= 1'b1;
						state_q <= S_RSP;
					end else if (sts.word_last) begin
						state_q <= S_RD;
					end
				end
				S_MOD: begin
					if (sts.run_done) state_q <= S_RSP;
					else if (sts.chunk_end) state_q <= S_WB;
				end
				S_WB:  state_q <= sts.run_done ? S_RSP : S_RD;
				S_RSP: if (rsp_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
